FILE: hw/rtl/tssp_pkg.sv
// shared types and constants for the station stop profiler
// no dependencies
package tssp_pkg;

    localparam logic [1:0] MODE_MOVING   = 2'd0;
    localparam logic [1:0] MODE_APPROACH = 2'd1;
    localparam logic [1:0] MODE_STOPPED  = 2'd2;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    // arrival window, 100 cm in Q24.8
    localparam logic signed [33:0] ARRIVE_DIST = 34'sd25600;

    localparam int DIV_STEPS = 48;

    localparam logic [2:0] REG_SPEED_LIMIT    = 3'd0;
    localparam logic [2:0] REG_ACCEL_RATE     = 3'd1;
    localparam logic [2:0] REG_BRAKE_LIMIT    = 3'd2;
    localparam logic [2:0] REG_DWELL_TIME     = 3'd3;
    localparam logic [2:0] REG_APPROACH_RANGE = 3'd4;
    localparam logic [2:0] REG_TRACK_LENGTH   = 3'd5;
    localparam logic [2:0] REG_STATION_COUNT  = 3'd6;

    typedef struct packed {
        logic        action;
        logic [15:0] delta_time;
        logic [3:0]  station_slot;
        logic [31:0] station_position;
    } t_in;

    typedef struct packed {
        logic [31:0] position;
        logic [23:0] speed;
        logic [1:0]  mode;
        logic [4:0]  next_station;
    } t_out;

    typedef struct packed {
        logic [23:0] speed_limit;
        logic [15:0] accel_rate;
        logic [15:0] brake_limit;
        logic [23:0] dwell_time;
        logic [31:0] approach_range;
        logic [31:0] track_length;
        logic [4:0]  station_count;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic load_wr;
        logic dwell;
        logic mul_acc;
        logic acc;
        logic mul_pos;
        logic pos;
        logic rd;
        logic dist_ld;
        logic mode_upd;
        logic div_init;
        logic div_step;
        logic mul_dec;
        logic brake;
        logic arrive;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic is_stopped;
        logic pending;
        logic approach_now;
        logic dist_pos;
        logic div_last;
    } t_sts;

endpackage

FILE: hw/rtl/train_station_stop_profiler_unit.sv
// top level of the station stop profiler: register file, sequencer, datapath
// depends on tssp_pkg, tssp_regs, tssp_ctrl, tssp_dp
//
// usage
// - input channel i_in_valid / o_in_stall carries t_in: a tick (elapsed time)
//   or a load that writes one station table entry
// - every input transaction yields exactly one result transaction on
//   o_out_valid / i_out_stall with position, speed, mode and next station
// - one transaction is worked at a time; o_in_stall is low only while idle
// - a load or a stopped tick goes from decode straight to the output register;
//   a moving tick accelerates, advances and reads the table; with a station
//   pending it updates the mode, and in approach range brakes if short of the
//   station (48-step serial divider for v^2 / 2d), then checks arrival
// - the result sits in an output register; a new input is taken while it
//   waits, and the next result is held back until the receiver takes it
// - reset (synchronous, active low) clears position, speed, mode, timer and
//   station index and restores register defaults; the station table is not
//   cleared and must be loaded before stations are counted
// - configuration writes use the apb-style port; user: idle only, unenforced
module train_station_stop_profiler_unit #(
    parameter int MAX_STATIONS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tssp_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tssp_pkg::t_out  o_out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    tssp_pkg::t_cfg w_cfg;
    tssp_pkg::t_cmd w_cmd;
    tssp_pkg::t_sts w_sts;

    // register file
    tssp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer owns the handshakes
    tssp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // motion state and arithmetic
    tssp_dp #(
        .MAX_STATIONS (MAX_STATIONS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );
endmodule

FILE: hw/rtl/tssp_regs.sv
// configuration register file behind the apb-style port
// depends on tssp_pkg
module tssp_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tssp_pkg::t_cfg      o_cfg
);
    tssp_pkg::t_cfg r_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit    <= 24'd256000;
            r_cfg.accel_rate     <= 16'd200;
            r_cfg.brake_limit    <= 16'd400;
            r_cfg.dwell_time     <= 24'd655360;
            r_cfg.approach_range <= 32'd512000;
            r_cfg.track_length   <= 32'hFFFF_FFFF;
            r_cfg.station_count  <= 5'd0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                tssp_pkg::REG_SPEED_LIMIT:    r_cfg.speed_limit    <= pwdata[23:0];
                tssp_pkg::REG_ACCEL_RATE:     r_cfg.accel_rate     <= pwdata[15:0];
                tssp_pkg::REG_BRAKE_LIMIT:    r_cfg.brake_limit    <= pwdata[15:0];
                tssp_pkg::REG_DWELL_TIME:     r_cfg.dwell_time     <= pwdata[23:0];
                tssp_pkg::REG_APPROACH_RANGE: r_cfg.approach_range <= pwdata;
                tssp_pkg::REG_TRACK_LENGTH:   r_cfg.track_length   <= pwdata;
                tssp_pkg::REG_STATION_COUNT:  r_cfg.station_count  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            tssp_pkg::REG_SPEED_LIMIT:    prdata = {8'd0, r_cfg.speed_limit};
            tssp_pkg::REG_ACCEL_RATE:     prdata = {16'd0, r_cfg.accel_rate};
            tssp_pkg::REG_BRAKE_LIMIT:    prdata = {16'd0, r_cfg.brake_limit};
            tssp_pkg::REG_DWELL_TIME:     prdata = {8'd0, r_cfg.dwell_time};
            tssp_pkg::REG_APPROACH_RANGE: prdata = r_cfg.approach_range;
            tssp_pkg::REG_TRACK_LENGTH:   prdata = r_cfg.track_length;
            tssp_pkg::REG_STATION_COUNT:  prdata = {27'd0, r_cfg.station_count};
            default:                      prdata = 32'd0;
        endcase
    end
endmodule

FILE: hw/rtl/tssp_ctrl.sv
// sequencer for one transaction at a time, plus the output valid flag
// depends on tssp_pkg
module tssp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  tssp_pkg::t_sts  i_sts,
    output tssp_pkg::t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_MULA  = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_MULP  = 4'd4;
    localparam logic [3:0] S_POS   = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_DIST  = 4'd7;
    localparam logic [3:0] S_MODE  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_MULD  = 4'd10;
    localparam logic [3:0] S_BRK   = 4'd11;
    localparam logic [3:0] S_ARR   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_out_valid;
    logic       w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
                if (i_in_valid) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.is_load) begin
                    o_cmd.load_wr = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.is_stopped) begin
                    o_cmd.dwell = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_MULA;
                end
            end
            S_MULA: begin
                o_cmd.mul_acc = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_MULP;
            end
            S_MULP: begin
                o_cmd.mul_pos = 1'b1;
                n_state = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = i_sts.pending ? S_DIST : S_OUT;
            end
            S_DIST: begin
                o_cmd.dist_ld = 1'b1;
                n_state = S_MODE;
            end
            S_MODE: begin
                o_cmd.mode_upd = 1'b1;
                if (!i_sts.approach_now) begin
                    n_state = S_OUT;
                end else if (i_sts.dist_pos) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_ARR;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_dec = 1'b1;
                n_state = S_BRK;
            end
            S_BRK: begin
                o_cmd.brake = 1'b1;
                n_state = S_ARR;
            end
            S_ARR: begin
                o_cmd.arrive = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_load = w_out_free;
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end
endmodule

FILE: hw/rtl/tssp_dp.sv
// motion state, station table, shared multiplier register and serial divider
// depends on tssp_pkg
module tssp_dp #(
    parameter int MAX_STATIONS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tssp_pkg::t_in   i_in_data,
    input  tssp_pkg::t_cfg  i_cfg,
    input  tssp_pkg::t_cmd  i_cmd,
    output tssp_pkg::t_sts  o_sts,
    output tssp_pkg::t_out  o_out_data
);
    localparam int IW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;

    tssp_pkg::t_in  r_item;
    tssp_pkg::t_out r_out;
    logic [31:0] r_pos;
    logic [23:0] r_speed;
    logic [1:0]  r_mode;
    logic [24:0] r_timer;
    logic [4:0]  r_idx;

    logic [31:0] r_table [MAX_STATIONS];
    logic [31:0] r_rdata;
    logic [39:0] r_prod;
    logic signed [33:0] r_dist;
    logic [47:0] r_quo;
    logic [33:0] r_rem;
    logic [33:0] r_div;
    logic [5:0]  r_cnt;

    logic [24:0] w_vsum;
    logic [32:0] w_psum;
    logic [24:0] w_tsum;
    logic [34:0] w_rsh;
    logic [34:0] w_diff;
    logic [23:0] w_cap;
    logic [23:0] w_dec;
    logic [23:0] w_drop;

    assign w_vsum = {1'b0, r_speed} + {1'b0, r_prod[31:8]};
    assign w_psum = {1'b0, r_pos} + {9'd0, r_prod[39:16]};
    assign w_tsum = r_timer + {9'd0, r_item.delta_time};
    assign w_rsh  = {r_rem, r_quo[47]};
    assign w_diff = w_rsh - {1'b0, r_div};
    assign w_cap  = {i_cfg.brake_limit, 8'd0};
    assign w_dec  = ((|r_quo[47:24]) || (r_quo[23:0] > w_cap)) ? w_cap : r_quo[23:0];
    assign w_drop = r_prod[39:16];

    assign o_sts.is_load      = (r_item.action == tssp_pkg::ACTION_LOAD);
    assign o_sts.is_stopped   = (r_mode == tssp_pkg::MODE_STOPPED);
    assign o_sts.pending      = (32'(r_idx) < MAX_STATIONS) && (r_idx < i_cfg.station_count);
    assign o_sts.approach_now = (r_dist <= $signed({2'b00, i_cfg.approach_range}))
                                || (r_mode == tssp_pkg::MODE_APPROACH);
    assign o_sts.dist_pos     = !r_dist[33] && (r_dist != '0);
    assign o_sts.div_last     = (r_cnt == 6'(tssp_pkg::DIV_STEPS - 1));
    assign o_out_data         = r_out;

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && (32'(r_item.station_slot) < MAX_STATIONS)) begin
            r_table[IW'(r_item.station_slot)] <= r_item.station_position;
        end
        if (i_cmd.rd) r_rdata <= r_table[IW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) r_item <= i_in_data;
        if (i_cmd.mul_acc) r_prod <= {8'd0, 32'(i_cfg.accel_rate) * 32'(r_item.delta_time)};
        if (i_cmd.mul_pos) r_prod <= 40'(r_speed) * 40'(r_item.delta_time);
        if (i_cmd.mul_dec) r_prod <= 40'(w_dec) * 40'(r_item.delta_time);
        if (i_cmd.dist_ld) r_dist <= $signed({2'b00, r_rdata}) - $signed({2'b00, r_pos});
        if (i_cmd.div_init) begin
            r_quo <= 48'(r_speed) * 48'(r_speed);
            r_rem <= '0;
            r_div <= {r_dist[32:0], 1'b0};
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[46:0], !w_diff[34]};
            r_rem <= w_diff[34] ? w_rsh[33:0] : w_diff[33:0];
            r_cnt <= r_cnt + 6'd1;
        end
        if (i_cmd.out_load) begin
            r_out.position     <= r_pos;
            r_out.speed        <= r_speed;
            r_out.mode         <= r_mode;
            r_out.next_station <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_speed <= '0;
            r_mode  <= tssp_pkg::MODE_MOVING;
            r_timer <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.dwell) begin
                if (w_tsum >= {1'b0, i_cfg.dwell_time}) begin
                    r_timer <= '0;
                    r_mode  <= tssp_pkg::MODE_MOVING;
                    r_speed <= '0;
                end else begin
                    r_timer <= w_tsum;
                end
            end
            if (i_cmd.acc && (r_speed < i_cfg.speed_limit)) begin
                r_speed <= (w_vsum > {1'b0, i_cfg.speed_limit}) ? i_cfg.speed_limit
                                                                 : w_vsum[23:0];
            end
            if (i_cmd.pos) begin
                if (w_psum > {1'b0, i_cfg.track_length}) begin
                    r_pos <= '0;
                    r_idx <= '0;
                end else begin
                    r_pos <= w_psum[31:0];
                end
            end
            if (i_cmd.mode_upd && (r_dist <= $signed({2'b00, i_cfg.approach_range}))) begin
                r_mode <= tssp_pkg::MODE_APPROACH;
            end
            if (i_cmd.brake) r_speed <= (w_drop >= r_speed) ? 24'd0 : r_speed - w_drop;
            if (i_cmd.arrive && (r_dist <= tssp_pkg::ARRIVE_DIST)) begin
                r_speed <= '0;
                r_mode  <= tssp_pkg::MODE_STOPPED;
                r_timer <= '0;
                r_idx   <= r_idx + 5'd1;
            end
        end
    end
endmodule

FILE: tb/tb_train_station_stop_profiler_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for train_station_stop_profiler_unit
// depends on tssp_pkg and the rtl of the block; no files, no arguments
module tb_train_station_stop_profiler_unit;

    localparam int NSTN       = 16;
    localparam int DRAIN_WAIT = 80;      // a little over the longest braking latency
    localparam int CYCLE_CAP  = 1500000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    tssp_pkg::t_in   i_in_data = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    tssp_pkg::t_out  o_out_data;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [4:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    train_station_stop_profiler_unit #(.MAX_STATIONS(NSTN)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow of the motion state and the register file
    tssp_pkg::t_cfg cfg_sh;
    logic [31:0] trk_pos;
    logic [23:0] spd;
    logic [1:0]  mot_mode;
    logic [24:0] dwell_acc;
    logic [4:0]  stn_idx;
    logic [31:0] stn_tbl [NSTN];

    tssp_pkg::t_out expected_q[$];
    int   err_cnt = 0;
    int   cyc = 0;
    int   burst_left = 0;

    // directed rows: typed expectation only where it is obvious
    typedef struct {
        tssp_pkg::t_in  d;
        bit             chk;
        tssp_pkg::t_out e;
    } t_row;
    t_row dir_rows[$];

    function automatic void motion_reset();
        cfg_sh.speed_limit    = 24'd256000;
        cfg_sh.accel_rate     = 16'd200;
        cfg_sh.brake_limit    = 16'd400;
        cfg_sh.dwell_time     = 24'd655360;
        cfg_sh.approach_range = 32'd512000;
        cfg_sh.track_length   = 32'hFFFF_FFFF;
        cfg_sh.station_count  = 5'd0;
        trk_pos   = '0;
        spd       = '0;
        mot_mode  = tssp_pkg::MODE_MOVING;
        dwell_acc = '0;
        stn_idx   = '0;
    endfunction

    // accelerate, advance, wrap
    function automatic void move_train(input logic [15:0] dt);
        logic [63:0] v;
        logic [63:0] p;
        if (spd < cfg_sh.speed_limit) begin
            v = 64'(spd) + ((64'(cfg_sh.accel_rate) * 64'(dt)) >> 8);
            if (v > 64'(cfg_sh.speed_limit))
                v = 64'(cfg_sh.speed_limit);
            spd = v[23:0];
        end
        p = 64'(trk_pos) + ((64'(spd) * 64'(dt)) >> 16);
        if (p > 64'(cfg_sh.track_length)) begin
            p = '0;
            stn_idx = '0;
        end
        trk_pos = p[31:0];
    endfunction

    // approach entry, braking and arrival at the pending station
    function automatic void brake_for_station(input logic [15:0] dt);
        int unsigned      n;
        longint           stn_gap;
        logic [63:0]      need, cap, dec, drop;
        n = (cfg_sh.station_count < NSTN) ? cfg_sh.station_count : NSTN;
        if (n == 0 || stn_idx >= n)
            return;
        stn_gap = longint'({32'd0, stn_tbl[stn_idx]}) - longint'({32'd0, trk_pos});
        if (stn_gap <= longint'({32'd0, cfg_sh.approach_range}))
            mot_mode = tssp_pkg::MODE_APPROACH;
        if (mot_mode != tssp_pkg::MODE_APPROACH)
            return;
        if (stn_gap > 0) begin
            need = (64'(spd) * 64'(spd)) / (64'(stn_gap) * 2);
            cap  = 64'(cfg_sh.brake_limit) << 8;
            dec  = (need < cap) ? need : cap;
            drop = (dec * 64'(dt)) >> 16;
            spd  = (drop >= 64'(spd)) ? 24'd0 : spd - drop[23:0];
        end
        if (stn_gap <= longint'(tssp_pkg::ARRIVE_DIST)) begin
            spd       = '0;
            mot_mode  = tssp_pkg::MODE_STOPPED;
            dwell_acc = '0;
            stn_idx   = stn_idx + 5'd1;
        end
    endfunction

    function automatic tssp_pkg::t_out next_profile(input tssp_pkg::t_in d);
        tssp_pkg::t_out r;
        if (d.action == tssp_pkg::ACTION_LOAD) begin
            stn_tbl[d.station_slot] = d.station_position;
        end else if (mot_mode == tssp_pkg::MODE_STOPPED) begin
            dwell_acc = dwell_acc + 25'(d.delta_time);
            if (dwell_acc >= 25'(cfg_sh.dwell_time)) begin
                dwell_acc = '0;
                mot_mode  = tssp_pkg::MODE_MOVING;
                spd       = '0;
            end
        end else begin
            move_train(d.delta_time);
            brake_for_station(d.delta_time);
        end
        r.position     = trk_pos;
        r.speed        = spd;
        r.mode         = mot_mode;
        r.next_station = stn_idx;
        return r;
    endfunction

    // apb write: setup then access, the register takes it at the access edge
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tssp_pkg::REG_SPEED_LIMIT:    cfg_sh.speed_limit    = val[23:0];
            tssp_pkg::REG_ACCEL_RATE:     cfg_sh.accel_rate     = val[15:0];
            tssp_pkg::REG_BRAKE_LIMIT:    cfg_sh.brake_limit    = val[15:0];
            tssp_pkg::REG_DWELL_TIME:     cfg_sh.dwell_time     = val[23:0];
            tssp_pkg::REG_APPROACH_RANGE: cfg_sh.approach_range = val;
            tssp_pkg::REG_TRACK_LENGTH:   cfg_sh.track_length   = val;
            tssp_pkg::REG_STATION_COUNT:  cfg_sh.station_count  = val[4:0];
            default: ;
        endcase
    endtask

    task automatic load_cfg(input tssp_pkg::t_cfg c);
        reg_write(tssp_pkg::REG_SPEED_LIMIT,    32'(c.speed_limit));
        reg_write(tssp_pkg::REG_ACCEL_RATE,     32'(c.accel_rate));
        reg_write(tssp_pkg::REG_BRAKE_LIMIT,    32'(c.brake_limit));
        reg_write(tssp_pkg::REG_DWELL_TIME,     32'(c.dwell_time));
        reg_write(tssp_pkg::REG_APPROACH_RANGE, c.approach_range);
        reg_write(tssp_pkg::REG_TRACK_LENGTH,   c.track_length);
        reg_write(tssp_pkg::REG_STATION_COUNT,  32'(c.station_count));
    endtask

    // one input transaction: optional gap, then hold until accepted
    task automatic send_item(input tssp_pkg::t_in d, input bit chk, input tssp_pkg::t_out e);
        tssp_pkg::t_out p;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (o_in_stall);
        p = next_profile(d);
        expected_q.push_back(chk ? e : p);
    endtask

    // quiet the input and let every outstanding result come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic tssp_pkg::t_in make_tick(input logic [15:0] dt);
        tssp_pkg::t_in d;
        d = '0;
        d.action     = tssp_pkg::ACTION_TICK;
        d.delta_time = dt;
        d.station_slot     = 4'($urandom);
        d.station_position = $urandom;
        return d;
    endfunction

    function automatic tssp_pkg::t_in make_load(input logic [3:0] slot,
                                                input logic [31:0] pos);
        tssp_pkg::t_in d;
        d.action           = tssp_pkg::ACTION_LOAD;
        d.delta_time       = 16'($urandom);
        d.station_slot     = slot;
        d.station_position = pos;
        return d;
    endfunction

    // a run segment: spread stations over the loop, then mostly ticks
    task automatic run_segment(input int n_items, input logic [31:0] span);
        tssp_pkg::t_out z;
        tssp_pkg::t_in  d;
        logic [31:0] pos;
        z = '0;
        for (int s = 0; s < NSTN; s++) begin
            pos = (span / NSTN) * s + $urandom_range(0, span / (NSTN * 2));
            send_item(make_load(4'(s), pos), 1'b0, z);
        end
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                // stray table rewrite, now and then anywhere in the 32-bit range
                pos = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, span);
                d = make_load(4'($urandom), pos);
            end else begin
                case ($urandom_range(0, 3))
                    0:       d = make_tick(16'($urandom));
                    1:       d = make_tick(16'($urandom_range(0, 4096)));
                    default: d = make_tick(16'($urandom_range(16384, 65535)));
                endcase
            end
            send_item(d, 1'b0, z);
        end
        settle();
    endtask

    // receiver: check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        tssp_pkg::t_out e;
        cyc <= cyc + 1;
        if (o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, o_out_data);
                err_cnt++;
            end else begin
                e = expected_q.pop_front();
                if (o_out_data.position !== e.position) begin
                    $display("%0t: position exp %h got %h", $time, e.position,
                             o_out_data.position);
                    err_cnt++;
                end
                if (o_out_data.speed !== e.speed) begin
                    $display("%0t: speed exp %h got %h", $time, e.speed, o_out_data.speed);
                    err_cnt++;
                end
                if (o_out_data.mode !== e.mode) begin
                    $display("%0t: mode exp %0d got %0d", $time, e.mode, o_out_data.mode);
                    err_cnt++;
                end
                if (o_out_data.next_station !== e.next_station) begin
                    $display("%0t: next_station exp %0d got %0d", $time, e.next_station,
                             o_out_data.next_station);
                    err_cnt++;
                end
            end
        end
        // stall pattern cycles through free, sparse, periodic and heavy
        case (cyc[10:9])
            2'd0:    i_out_stall <= 1'b0;
            2'd1:    i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    i_out_stall <= cyc[2];
            default: i_out_stall <= ($urandom_range(0, 2) != 0);
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cyc > CYCLE_CAP) begin
            $display("** train_station_stop_profiler_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        tssp_pkg::t_cfg  c;
        tssp_pkg::t_out  z;
        t_row  r;
        logic [31:0] span;
        z = '0;
        motion_reset();
        for (int s = 0; s < NSTN; s++)
            stn_tbl[s] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill the whole table first, so no unwritten entry is ever read
        for (int s = 0; s < NSTN; s++) begin
            r.d   = make_load(4'(s), (s == 0) ? 32'd0 :
                              (s == NSTN - 1) ? 32'hFFFF_FFFF : 32'(s) * 32'd200000);
            r.chk = 1'b1;
            r.e   = z;
            dir_rows.push_back(r);
        end
        // zero time tick from rest changes nothing
        r.d = make_tick(16'd0); r.chk = 1'b1; r.e = z;
        dir_rows.push_back(r);
        // longest and shortest ticks with no station pending
        r.d = make_tick(16'hFFFF); r.chk = 1'b0;
        dir_rows.push_back(r);
        r.d = make_tick(16'd1);
        dir_rows.push_back(r);
        r.d = make_tick(16'hFFFF);
        dir_rows.push_back(r);
        foreach (dir_rows[i])
            send_item(dir_rows[i].d, dir_rows[i].chk, dir_rows[i].e);
        settle();

        // upper extremes, station count beyond the table: passed station at zero
        c.speed_limit    = 24'hFF_FFFF;
        c.accel_rate     = 16'hFFFF;
        c.brake_limit    = 16'hFFFF;
        c.dwell_time     = 24'd0;
        c.approach_range = 32'hFFFF_FFFF;
        c.track_length   = 32'hFFFF_FFFF;
        c.station_count  = 5'd31;
        load_cfg(c);
        run_segment(90, 32'hFFFF_FFFF);

        // lower extremes: zero track wraps every move, speed above a zero limit is kept
        c = '0;
        load_cfg(c);
        run_segment(50, 32'h0010_0000);

        // randomized settings on short loops so stations come round often
        for (int ph = 0; ph < 8; ph++) begin
            span             = $urandom_range(32'h0010_0000, 32'h0080_0000);
            c.speed_limit    = 24'($urandom_range(2000, 1200000));
            c.accel_rate     = 16'($urandom_range(20, 3000));
            c.brake_limit    = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                               16'($urandom_range(50, 2000));
            c.dwell_time     = 24'($urandom_range(0, 300000));
            c.approach_range = $urandom_range(0, span / 4);
            c.track_length   = span;
            c.station_count  = 5'($urandom_range(1, 16));
            load_cfg(c);
            run_segment(130, span);
        end

        if (err_cnt == 0)
            $display("** train_station_stop_profiler_unit: PASSED **");
        else
            $display("** train_station_stop_profiler_unit: FAILED **");
        $finish;
    end

    // any result still outstanding at the end is caught by settle and the watchdog
endmodule

FILE: sim.f
hw/rtl/tssp_pkg.sv
hw/rtl/tssp_regs.sv
hw/rtl/tssp_ctrl.sv
hw/rtl/tssp_dp.sv
hw/rtl/train_station_stop_profiler_unit.sv
tb/tb_train_station_stop_profiler_unit.sv
